// ===== design/esm_pkg.sv =====
// shared types, constants and register codes for the encoder speed meter
package esm_pkg;

	// counter width used from the raw reading
	localparam int CNT_BITS = 16;

	// history depth is a power of two so the mean is a shift
	localparam int HIST_LOG2 = 3;
	localparam int HIST_DEPTH = 1 << HIST_LOG2;
	localparam int SUM_W = 32 + HIST_LOG2;

	localparam logic [16:0] RELOAD_RST = 17'd65536;
	localparam logic [15:0] THRESHOLD_RST = 16'd19000;
	localparam logic [31:0] GAIN_RST = 32'd65536;

	typedef enum logic [1:0] {
		REG_RELOAD = 2'd0,
		REG_THRESHOLD = 2'd1,
		REG_GAIN = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [16:0] reload_value;
		logic [15:0] wrap_threshold;
		logic [31:0] speed_gain;
	} cfg_t;

	typedef struct packed {
		logic [15:0] counter_value;
		logic counting_down;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] filtered_speed;
		logic signed [31:0] raw_speed;
		logic signed [31:0] count_delta;
		logic direction;
	} out_item_t;

	// count change and direction moving down the pipeline
	typedef struct packed {
		logic [31:0] count_delta;
		logic direction;
	} delta_t;

endpackage

// ===== design/encoder_speed_meter_core.sv =====
// top level of the encoder speed meter: config registers, pipeline control
//
// channel  | direction | handshake         | payload
// in       | input     | in_valid/in_stall   | in_data (counter_value, counting_down)
// out      | output    | out_valid/out_stall | out_data (filtered_speed, raw_speed,
//          |           |                     |   count_delta, direction)
// cfg      | input     | cfg_write           | cfg_index, cfg_data
//
// one transaction per cycle sustained while out_stall is low, through the input, delta,
// product, speed and result registers; the wrap offset and previous total close their
// loop in the single unwrap stage, so consecutive samples follow each other with no gap
// reset clears the config registers to their defaults, the totals, the
// speed history and all stage valid bits
// each stage moves when the stage after it is empty or moving, so a stalled
// result only holds up the stages behind it once they fill
module encoder_speed_meter_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input esm_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output esm_pkg::out_item_t out_data,
	input logic cfg_write,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);

	esm_pkg::cfg_t cfg_q;

	// stage valid bits: s1 input reg, s2 delta, s3 product, s4 speed, out result
	logic s1_valid_q;
	logic s2_valid_q;
	logic s3_valid_q;
	logic s4_valid_q;
	logic out_valid_q;

	logic out_rdy;
	logic s4_rdy;
	logic s3_rdy;
	logic s2_rdy;
	logic s1_rdy;

	esm_pkg::in_item_t item_s1;
	esm_pkg::delta_t delta_s2;
	esm_pkg::delta_t delta_s4;
	logic signed [31:0] speed_s4;

	// config writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reload_value <= esm_pkg::RELOAD_RST;
			cfg_q.wrap_threshold <= esm_pkg::THRESHOLD_RST;
			cfg_q.speed_gain <= esm_pkg::GAIN_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				esm_pkg::REG_RELOAD: cfg_q.reload_value <= cfg_data[16:0];
				esm_pkg::REG_THRESHOLD: cfg_q.wrap_threshold <= cfg_data[15:0];
				esm_pkg::REG_GAIN: cfg_q.speed_gain <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage can take a new transaction when empty or when it hands on its own
	assign out_rdy = !out_valid_q || !out_stall;
	assign s4_rdy = !s4_valid_q || out_rdy;
	assign s3_rdy = !s3_valid_q || s4_rdy;
	assign s2_rdy = !s2_valid_q || s3_rdy;
	assign s1_rdy = !s1_valid_q || s2_rdy;

	assign in_stall = !s1_rdy;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			s3_valid_q <= 1'b0;
			s4_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_rdy) begin
				s1_valid_q <= in_valid;
			end
			if (s2_rdy) begin
				s2_valid_q <= s1_valid_q;
			end
			if (s3_rdy) begin
				s3_valid_q <= s2_valid_q;
			end
			if (s4_rdy) begin
				s4_valid_q <= s3_valid_q;
			end
			if (out_rdy) begin
				out_valid_q <= s4_valid_q;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_valid && s1_rdy) begin
			item_s1 <= in_data;
		end
	end

	// state only advances on real transactions, never on bubbles
	esm_unwrap u_unwrap (
		.clk(clk),
		.arst_n(arst_n),
		.load(s1_valid_q && s2_rdy),
		.cfg(cfg_q),
		.item_s1(item_s1),
		.delta_s2(delta_s2)
	);

	esm_scale u_scale (
		.clk(clk),
		.load_mul(s2_valid_q && s3_rdy),
		.load_sat(s3_valid_q && s4_rdy),
		.speed_gain(cfg_q.speed_gain),
		.delta_s2(delta_s2),
		.delta_s4(delta_s4),
		.speed_s4(speed_s4)
	);

	esm_avg u_avg (
		.clk(clk),
		.arst_n(arst_n),
		.load(s4_valid_q && out_rdy),
		.delta_s4(delta_s4),
		.speed_s4(speed_s4),
		.result(out_data)
	);

endmodule

// ===== design/esm_unwrap.sv =====
// counter extension with wrap offset tracking and count delta
module esm_unwrap (
	input logic clk,
	input logic arst_n,
	input logic load,
	input esm_pkg::cfg_t cfg,
	input esm_pkg::in_item_t item_s1,
	output esm_pkg::delta_t delta_s2
);

	logic [31:0] prev_total_q;
	logic [31:0] wrap_offset_q;
	logic [31:0] counter_ext;
	logic [31:0] reload_ext;
	logic [31:0] total0;
	logic [31:0] diff0;
	logic [31:0] diff0_neg;
	logic wrap_up;
	logic wrap_down;
	logic [31:0] total_next;
	logic [31:0] offset_next;
	logic [31:0] delta_next;

	assign counter_ext = {{(32 - esm_pkg::CNT_BITS){1'b0}},
		item_s1.counter_value[esm_pkg::CNT_BITS-1:0]};
	assign reload_ext = {15'd0, cfg.reload_value};
	assign total0 = counter_ext + wrap_offset_q;
	assign diff0 = total0 - prev_total_q;
	assign diff0_neg = prev_total_q - total0;

	// signed differences tested against the threshold, 33-bit compare
	assign wrap_up = $signed({diff0_neg[31], diff0_neg}) > $signed({17'd0, cfg.wrap_threshold});
	assign wrap_down = $signed({diff0[31], diff0}) > $signed({17'd0, cfg.wrap_threshold});

	always_comb begin
		if (wrap_up) begin
			offset_next = wrap_offset_q + reload_ext;
			total_next = total0 + reload_ext;
			delta_next = diff0 + reload_ext;
		end else if (wrap_down) begin
			offset_next = wrap_offset_q - reload_ext;
			total_next = total0 - reload_ext;
			delta_next = diff0 - reload_ext;
		end else begin
			offset_next = wrap_offset_q;
			total_next = total0;
			delta_next = diff0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_total_q <= '0;
			wrap_offset_q <= '0;
		end else if (load) begin
			prev_total_q <= total_next;
			wrap_offset_q <= offset_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			delta_s2.count_delta <= delta_next;
			delta_s2.direction <= item_s1.counting_down;
		end
	end

endmodule

// ===== design/esm_scale.sv =====
// gain multiply and saturation to a signed q16.16 speed
module esm_scale (
	input logic clk,
	input logic load_mul,
	input logic load_sat,
	input logic [31:0] speed_gain,
	input esm_pkg::delta_t delta_s2,
	output esm_pkg::delta_t delta_s4,
	output logic signed [31:0] speed_s4
);

	logic [31:0] mag;
	logic [63:0] prod_s3;
	logic neg_s3;
	esm_pkg::delta_t delta_s3;
	logic [31:0] neg_low;
	logic [31:0] speed_next;

	// magnitude of a 32-bit two's complement value, -2^31 maps to 2^31
	assign mag = delta_s2.count_delta[31] ? (32'd0 - delta_s2.count_delta)
		: delta_s2.count_delta;

	always_ff @(posedge clk) begin
		if (load_mul) begin
			prod_s3 <= {32'd0, mag} * {32'd0, speed_gain};
			neg_s3 <= delta_s2.count_delta[31];
			delta_s3 <= delta_s2;
		end
	end

	assign neg_low = 32'd0 - prod_s3[31:0];

	always_comb begin
		if (neg_s3) begin
			if (prod_s3 > 64'h0000_0000_8000_0000) begin
				speed_next = 32'h8000_0000;
			end else begin
				speed_next = neg_low;
			end
		end else begin
			if (prod_s3 > 64'h0000_0000_7FFF_FFFF) begin
				speed_next = 32'h7FFF_FFFF;
			end else begin
				speed_next = prod_s3[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_sat) begin
			speed_s4 <= speed_next;
			delta_s4 <= delta_s3;
		end
	end

endmodule

// ===== design/esm_avg.sv =====
// speed history line with running sum and the output result register
module esm_avg (
	input logic clk,
	input logic arst_n,
	input logic load,
	input esm_pkg::delta_t delta_s4,
	input logic signed [31:0] speed_s4,
	output esm_pkg::out_item_t result
);

	logic [31:0] hist_q [esm_pkg::HIST_DEPTH];
	logic [esm_pkg::SUM_W-1:0] sum_q;
	logic [esm_pkg::SUM_W-1:0] speed_ext;
	logic [esm_pkg::SUM_W-1:0] oldest_ext;
	logic [esm_pkg::SUM_W-1:0] biased;
	logic [31:0] speed_q;
	esm_pkg::delta_t delta_q;

	assign speed_ext = {{esm_pkg::HIST_LOG2{speed_s4[31]}}, speed_s4};
	assign oldest_ext = {{esm_pkg::HIST_LOG2{hist_q[esm_pkg::HIST_DEPTH-1][31]}},
		hist_q[esm_pkg::HIST_DEPTH-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			for (int i = 0; i < esm_pkg::HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else if (load) begin
			sum_q <= sum_q + speed_ext - oldest_ext;
			hist_q[0] <= speed_s4;
			for (int i = 1; i < esm_pkg::HIST_DEPTH; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			speed_q <= speed_s4;
			delta_q <= delta_s4;
		end
	end

	// mean truncated toward zero: bias negative sums before the shift
	assign biased = sum_q[esm_pkg::SUM_W-1]
		? sum_q + esm_pkg::SUM_W'(esm_pkg::HIST_DEPTH - 1) : sum_q;

	assign result.filtered_speed = biased[esm_pkg::HIST_LOG2 +: 32];
	assign result.raw_speed = speed_q;
	assign result.count_delta = delta_q.count_delta;
	assign result.direction = delta_q.direction;

endmodule
